// ===== rtl/i2cmm_pkg.sv =====
// Package for the two-byte-address I2C memory master.
// Holds phase, byte-stage, opcode and register index codes; no dependencies.
package i2cmm_pkg;

    localparam int PHASE_W = 3;
    localparam int STAGE_W = 3;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [STAGE_W-1:0] stage_t;
    typedef logic [1:0]         opcode_t;
    typedef logic [1:0]         cfg_index_t;

    // Bus sequencer phases
    localparam phase_t PH_IDLE  = 3'd0;
    localparam phase_t PH_START = 3'd1;
    localparam phase_t PH_TX    = 3'd2;
    localparam phase_t PH_ACK   = 3'd3;
    localparam phase_t PH_WAIT  = 3'd4;
    localparam phase_t PH_RX    = 3'd5;
    localparam phase_t PH_MACK  = 3'd6;
    localparam phase_t PH_STOP  = 3'd7;

    // Which byte of the frame is on the bus
    localparam stage_t ST_DEVW = 3'd0;
    localparam stage_t ST_AHI  = 3'd1;
    localparam stage_t ST_ALO  = 3'd2;
    localparam stage_t ST_DATA = 3'd3;
    localparam stage_t ST_DEVR = 3'd4;

    // Command codes
    localparam opcode_t OP_TICK  = 2'd0;
    localparam opcode_t OP_WRITE = 2'd1;
    localparam opcode_t OP_READ  = 2'd2;
    localparam opcode_t OP_DATA  = 2'd3;

    // Register indexes
    localparam cfg_index_t CFG_WRITE_DEV   = 2'd0;
    localparam cfg_index_t CFG_READ_DEV    = 2'd1;
    localparam cfg_index_t CFG_ACK_TIMEOUT = 2'd2;
    localparam cfg_index_t CFG_QUARTER     = 2'd3;

    localparam logic [7:0] RESET_WRITE_DEV   = 8'd160;
    localparam logic [7:0] RESET_READ_DEV    = 8'd161;
    localparam logic [7:0] RESET_ACK_TIMEOUT = 8'd255;
    localparam logic [7:0] RESET_QUARTER     = 8'd2;
    localparam logic [7:0] TIMEOUT_MAX       = 8'd255;

endpackage

// ===== rtl/i2c_memory_master_unit.sv =====
// Top level of the tick-driven I2C master for memories with two address bytes.
// Depends on i2cmm_pkg for phase, stage, opcode and register codes.
//
// Every accepted input transfer is one tick of the bus sequencer and yields
// exactly one result transfer carrying the bus levels (scl, sda_out,
// sda_drive) and flags as they stand after that tick. A bus bit slot has four
// quarters of quarter_ticks ticks each; SCL is low in quarters 0 and 1 and
// high in 2 and 3. A write command (opcode 1) sends START, the write device
// byte, the high address byte masked to 7 bits, the low address byte and then
// the data bytes; before each data byte the engine raises data_request, holds SCL
// low and waits for an opcode 3 tick that supplies the byte. A read command
// (opcode 2) sends the address phase, a repeated START and the read device
// byte, then shifts in bytes MSB first, ACKing all but the last, NACKing the
// last, and closes with STOP. Burst length 0 means 256 bytes. When the slave
// keeps SDA high in the ACK slot for ack_timeout ticks, the engine aborts,
// sends STOP and flags nack_error together with done_res. The next state and
// result of a tick are formed from the sequencer registers and the incoming
// transfer in one pass and land in the result register, so a new tick is
// accepted every cycle while the result side keeps up; in_ready drops only
// while an untaken result sits in the result register.
// Registers are written through the cfg port, one transfer per cycle, and are
// meant to change only while the engine is idle.
module i2c_memory_master_unit
    import i2cmm_pkg::*;
#(
    parameter int ADDR_BITS = 15
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [ADDR_BITS-1:0] mem_address,
    input  logic [7:0]           burst_length,
    input  logic [7:0]           write_data,
    input  logic                 sda_in,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 scl,
    output logic                 sda_out,
    output logic                 sda_drive,
    output logic [7:0]           read_data,
    output logic                 read_valid,
    output logic                 data_request,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 nack_error
);

    // Configuration registers
    logic [7:0] write_dev_reg, read_dev_reg, ack_timeout_reg, quarter_ticks_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    stage_t                stage_reg, stage_next;
    logic [1:0]            qtr_reg, qtr_next;
    logic [7:0]            quarter_count_reg, quarter_count_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            bytes_left_reg, bytes_left_next;
    logic [ADDR_BITS-1:0]  address_reg, address_next;
    logic [7:0]            timeout_count_reg, timeout_count_next;
    logic                  is_read_reg, is_read_next;
    logic                  failed_reg, failed_next;

    // Result register
    logic                  out_valid_reg;
    logic                  scl_reg, sda_out_reg, sda_drive_reg;
    logic [7:0]            read_data_reg;
    logic                  read_valid_reg, data_request_reg, busy_reg, done_reg, nack_reg;

    logic                  scl_next, sda_out_next, sda_drive_next;
    logic [7:0]            read_data_next;
    logic                  read_valid_next, done_next, nack_next;

    logic                  in_fire;
    logic [7:0]            quarter_limit;
    logic [7:0]            qc_inc;
    logic                  quarter_done;
    logic [15:0]           addr_wide;
    logic [7:0]            timeout_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // Zero quarter length behaves as one tick
    assign quarter_limit = (quarter_ticks_reg == 8'd0) ? 8'd1 : quarter_ticks_reg;
    assign qc_inc        = quarter_count_reg + 8'd1;
    assign quarter_done  = (qc_inc >= quarter_limit);
    assign addr_wide     = 16'(address_reg);
    assign timeout_inc   = (timeout_count_reg < TIMEOUT_MAX) ? timeout_count_reg + 8'd1
                                                             : timeout_count_reg;

    // Next sequencer state for one tick
    always_comb
    begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        qtr_next           = qtr_reg;
        quarter_count_next = quarter_count_reg;
        bit_count_next     = bit_count_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        address_next       = address_reg;
        timeout_count_next = timeout_count_reg;
        is_read_next       = is_read_reg;
        failed_next        = failed_reg;
        read_valid_next    = 1'b0;
        read_data_next     = 8'd0;
        done_next          = 1'b0;
        nack_next          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (opcode == OP_WRITE || opcode == OP_READ)
                begin
                    address_next       = mem_address;
                    bytes_left_next    = burst_length - 8'd1;
                    is_read_next       = (opcode == OP_READ);
                    stage_next         = ST_DEVW;
                    failed_next        = 1'b0;
                    phase_next         = PH_START;
                    qtr_next           = 2'd0;
                    quarter_count_next = 8'd0;
                    bit_count_next     = 3'd0;
                end
            end
            PH_START:
            begin
                if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else
                    begin
                        shift_next     = (stage_reg == ST_DEVR) ? read_dev_reg : write_dev_reg;
                        phase_next     = PH_TX;
                        qtr_next       = 2'd0;
                        bit_count_next = 3'd0;
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            PH_TX:
            begin
                if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else if (bit_count_reg != 3'd7)
                    begin
                        bit_count_next = bit_count_reg + 3'd1;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        qtr_next       = 2'd0;
                    end
                    else
                    begin
                        phase_next         = PH_ACK;
                        qtr_next           = 2'd0;
                        bit_count_next     = 3'd0;
                        timeout_count_next = 8'd0;
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            PH_ACK:
            begin
                if (qtr_reg == 2'd2 && sda_in)
                begin
                    // Stretch the high quarter while the slave withholds ACK
                    timeout_count_next = timeout_inc;
                    if (timeout_inc >= ack_timeout_reg)
                    begin
                        failed_next        = 1'b1;
                        phase_next         = PH_STOP;
                        qtr_next           = 2'd0;
                        quarter_count_next = 8'd0;
                        bit_count_next     = 3'd0;
                    end
                end
                else if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else
                    begin
                        qtr_next       = 2'd0;
                        bit_count_next = 3'd0;
                        case (stage_reg)
                            ST_DEVW:
                            begin
                                shift_next = {1'b0, addr_wide[14:8]};
                                stage_next = ST_AHI;
                                phase_next = PH_TX;
                            end
                            ST_AHI:
                            begin
                                shift_next = addr_wide[7:0];
                                stage_next = ST_ALO;
                                phase_next = PH_TX;
                            end
                            ST_ALO:
                            begin
                                if (is_read_reg)
                                begin
                                    stage_next = ST_DEVR;
                                    phase_next = PH_START;
                                end
                                else
                                begin
                                    stage_next = ST_DATA;
                                    phase_next = PH_WAIT;
                                end
                            end
                            ST_DATA:
                            begin
                                if (bytes_left_reg == 8'd0)
                                    phase_next = PH_STOP;
                                else
                                begin
                                    bytes_left_next = bytes_left_reg - 8'd1;
                                    phase_next      = PH_WAIT;
                                end
                            end
                            default:
                                phase_next = PH_RX;
                        endcase
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            PH_WAIT:
            begin
                if (opcode == OP_DATA)
                begin
                    shift_next         = write_data;
                    phase_next         = PH_TX;
                    qtr_next           = 2'd0;
                    quarter_count_next = 8'd0;
                    bit_count_next     = 3'd0;
                end
            end
            PH_RX:
            begin
                if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    // Sample at the end of the first high quarter
                    if (qtr_reg == 2'd2)
                        shift_next = {shift_reg[6:0], sda_in};
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else if (bit_count_reg != 3'd7)
                    begin
                        bit_count_next = bit_count_reg + 3'd1;
                        qtr_next       = 2'd0;
                    end
                    else
                    begin
                        read_valid_next = 1'b1;
                        read_data_next  = shift_reg;
                        phase_next      = PH_MACK;
                        qtr_next        = 2'd0;
                        bit_count_next  = 3'd0;
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            PH_MACK:
            begin
                if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else
                    begin
                        qtr_next       = 2'd0;
                        bit_count_next = 3'd0;
                        if (bytes_left_reg == 8'd0)
                            phase_next = PH_STOP;
                        else
                        begin
                            bytes_left_next = bytes_left_reg - 8'd1;
                            phase_next      = PH_RX;
                        end
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            PH_STOP:
            begin
                if (quarter_done)
                begin
                    quarter_count_next = 8'd0;
                    if (qtr_reg != 2'd3)
                        qtr_next = qtr_reg + 2'd1;
                    else
                    begin
                        done_next      = 1'b1;
                        nack_next      = failed_reg;
                        phase_next     = PH_IDLE;
                        qtr_next       = 2'd0;
                        bit_count_next = 3'd0;
                    end
                end
                else
                    quarter_count_next = qc_inc;
            end
            default:
            begin
                phase_next         = PH_IDLE;
                qtr_next           = 2'd0;
                quarter_count_next = 8'd0;
                bit_count_next     = 3'd0;
            end
        endcase
    end

    // Bus levels follow the state after the tick
    always_comb
    begin
        scl_next       = 1'b1;
        sda_out_next   = 1'b1;
        sda_drive_next = 1'b0;
        case (phase_next)
            PH_START:
            begin
                scl_next       = (qtr_next == 2'd1) || (qtr_next == 2'd2);
                sda_out_next   = !qtr_next[1];
                sda_drive_next = 1'b1;
            end
            PH_TX:
            begin
                scl_next       = qtr_next[1];
                sda_out_next   = shift_next[7];
                sda_drive_next = 1'b1;
            end
            PH_MACK:
            begin
                scl_next       = qtr_next[1];
                sda_out_next   = (bytes_left_next == 8'd0);
                sda_drive_next = 1'b1;
            end
            PH_ACK, PH_RX:
            begin
                scl_next = qtr_next[1];
            end
            PH_WAIT:
            begin
                scl_next = 1'b0;
            end
            PH_STOP:
            begin
                scl_next       = (qtr_next != 2'd0);
                sda_out_next   = qtr_next[1];
                sda_drive_next = 1'b1;
            end
            default:
            begin
                scl_next = 1'b1;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_dev_reg     <= RESET_WRITE_DEV;
            read_dev_reg      <= RESET_READ_DEV;
            ack_timeout_reg   <= RESET_ACK_TIMEOUT;
            quarter_ticks_reg <= RESET_QUARTER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WRITE_DEV:   write_dev_reg     <= cfg_data;
                CFG_READ_DEV:    read_dev_reg      <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg   <= cfg_data;
                CFG_QUARTER:     quarter_ticks_reg <= cfg_data;
                default:         write_dev_reg     <= write_dev_reg;
            endcase
        end
    end

    // Advance the sequencer on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= ST_DEVW;
            qtr_reg           <= 2'd0;
            quarter_count_reg <= 8'd0;
            bit_count_reg     <= 3'd0;
            shift_reg         <= 8'd0;
            bytes_left_reg    <= 8'd0;
            address_reg       <= '0;
            timeout_count_reg <= 8'd0;
            is_read_reg       <= 1'b0;
            failed_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            qtr_reg           <= qtr_next;
            quarter_count_reg <= quarter_count_next;
            bit_count_reg     <= bit_count_next;
            shift_reg         <= shift_next;
            bytes_left_reg    <= bytes_left_next;
            address_reg       <= address_next;
            timeout_count_reg <= timeout_count_next;
            is_read_reg       <= is_read_next;
            failed_reg        <= failed_next;
        end
    end

    // Result register: load on a tick, drop valid once the transfer is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            scl_reg          <= 1'b1;
            sda_out_reg      <= 1'b1;
            sda_drive_reg    <= 1'b0;
            read_data_reg    <= 8'd0;
            read_valid_reg   <= 1'b0;
            data_request_reg <= 1'b0;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            nack_reg         <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg    <= 1'b1;
            scl_reg          <= scl_next;
            sda_out_reg      <= sda_out_next;
            sda_drive_reg    <= sda_drive_next;
            read_data_reg    <= read_data_next;
            read_valid_reg   <= read_valid_next;
            data_request_reg <= (phase_next == PH_WAIT);
            busy_reg         <= (phase_next != PH_IDLE);
            done_reg         <= done_next;
            nack_reg         <= nack_next;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign scl          = scl_reg;
    assign sda_out      = sda_out_reg;
    assign sda_drive    = sda_drive_reg;
    assign read_data    = read_data_reg;
    assign read_valid   = read_valid_reg;
    assign data_request = data_request_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign nack_error   = nack_reg;

`ifndef SYNTH
    // Every accepted tick leaves a result waiting
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // An abort is only reported on the closing STOP
    a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        nack_reg |-> done_reg)
        else $error("nack_error without done_res");

    // Completion returns the engine to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && phase_reg == PH_IDLE))
        else $error("done_res while still busy");

    // A received byte is followed by the master driving ACK or NACK
    a_rx_then_mack: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid_reg |-> (sda_drive_reg && phase_reg == PH_MACK))
        else $error("read byte not followed by master acknowledge");

    // While waiting for a write byte the clock is held low and SDA released
    a_wait_bus: assert property (@(posedge clk) disable iff (!rst_n)
        data_request_reg |-> (!scl_reg && !sda_drive_reg))
        else $error("bus not parked while waiting for data");
`endif

endmodule
